/* src/wdcsr_pkg.sv */
// Shared types and constants for the windowed duty-cycle sleep regulator.
`default_nettype none

package wdcsr_pkg;

  localparam int TS_BITS        = 64;
  localparam int USAGE_BITS     = 17;
  localparam int QUO_BITS       = USAGE_BITS - 1;
  localparam int FACTOR_BITS    = 31;
  localparam int WLEN_BITS      = 11;
  localparam int SLEEP_BITS     = 48;
  localparam int SLEEP_HALF     = SLEEP_BITS / 2;
  localparam int SLEEP_NS_BITS  = 32;
  localparam int BAND_BITS      = 2;
  localparam int Q_SHIFT        = 30;
  localparam int PROD_BITS      = SLEEP_HALF + FACTOR_BITS;
  localparam int SCALE_BITS     = SLEEP_BITS + FACTOR_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = FACTOR_BITS;

  localparam logic [USAGE_BITS-1:0] ONE_Q16   = 17'h10000;
  localparam logic [SLEEP_BITS-1:0] SLEEP_ONE = 48'h10000;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GROW_FACTOR    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHRINK_FACTOR  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH  = 3'd4;

  // register reset values
  localparam logic [USAGE_BITS-1:0]  RST_LOW_THRESHOLD  = 17'd596;
  localparam logic [USAGE_BITS-1:0]  RST_HIGH_THRESHOLD = 17'd721;
  localparam logic [FACTOR_BITS-1:0] RST_GROW_FACTOR    = 31'd1073844167;
  localparam logic [FACTOR_BITS-1:0] RST_SHRINK_FACTOR  = 31'd1073639490;
  localparam logic [WLEN_BITS-1:0]   RST_WINDOW_LENGTH  = 11'd1000;

  // band codes
  localparam logic [BAND_BITS-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_BITS-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_BITS-1:0] BAND_HIGH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_DIV,
    ST_DIV_WAIT,
    ST_CLASSIFY,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* src/wdcsr_in_if.sv */
// Sample channel: valid/ready handshake with mode and the two timestamps.
`default_nettype none

interface wdcsr_in_if import wdcsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [TS_BITS-1:0] wall_time;
  logic [TS_BITS-1:0] busy_time;

  modport source (output valid, output mode, output wall_time, output busy_time,
                  input ready);
  modport sink (input valid, input mode, input wall_time, input busy_time,
                output ready);
endinterface

`default_nettype wire

/* src/wdcsr_out_if.sv */
// Result channel: valid/ready handshake with sleep, usage, band and fill flag.
`default_nettype none

interface wdcsr_out_if import wdcsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SLEEP_NS_BITS-1:0] sleep_ns;
  logic [USAGE_BITS-1:0]    usage_q16;
  logic [BAND_BITS-1:0]     band;
  logic                     window_full;

  modport source (output valid, output sleep_ns, output usage_q16, output band,
                  output window_full, input ready);
  modport sink (input valid, input sleep_ns, input usage_q16, input band,
                input window_full, output ready);
endinterface

`default_nettype wire

/* src/wdcsr_divider.sv */
// Restoring divider giving busy/wall as Q1.16, one quotient bit per cycle.
`default_nettype none

module wdcsr_divider import wdcsr_pkg::*; #(
  parameter int SUM_BITS = 51
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [SUM_BITS-1:0]   divisor,
  output logic                  done,
  output logic [USAGE_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(QUO_BITS);

  logic                 active;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS:0]    rem;
  logic [SUM_BITS:0]    rem_shift;
  logic [SUM_BITS:0]    rem_next;
  logic [SUM_BITS-1:0]  divisor_r;
  logic [QUO_BITS-1:0]  quo;
  logic                 ge;
  logic                 trivial;

  assign trivial   = (divisor == '0) || (dividend >= divisor);
  assign rem_shift = {rem[SUM_BITS-1:0], 1'b0};
  assign ge        = rem_shift >= {1'b0, divisor_r};
  assign rem_next  = ge ? (rem_shift - {1'b0, divisor_r}) : rem_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (trivial) begin
          done <= 1'b1;
        end else begin
          active <= 1'b1;
        end
      end else if (active) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(QUO_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= {1'b0, dividend};
      divisor_r <= divisor;
      quo       <= '0;
      if (trivial) begin
        quotient <= ONE_Q16;
      end
    end else if (active) begin
      rem <= rem_next;
      quo <= {quo[QUO_BITS-2:0], ge};
      if (step == STEP_BITS'(QUO_BITS - 1)) begin
        quotient <= {1'b0, quo[QUO_BITS-2:0], ge};
      end
    end
  end

endmodule

`default_nettype wire

/* src/windowed_duty_cycle_sleep_regulator.sv */
// Top level of the windowed duty-cycle sleep regulator.
// Each sample transaction carries a wall-clock and a busy-time timestamp. A
// regular sample (mode 0) forms saturated deltas against the previous
// timestamps, keeps them in a ring of RING_DEPTH entries and maintains running
// sums over the last window_length samples. Usage = busy_sum / wall_sum is
// formed as Q1.16 (1.0 when wall_sum is zero or busy >= wall). Usage below
// usage_low_threshold scales the Q32.16 sleep value by shrink_factor (Q1.30),
// usage above usage_high_threshold scales it by grow_factor; a shrink to zero
// snaps back to 1.0 and both saturate at 48 bits. A restart sample (mode 1)
// clears the window and only records the timestamps. One result transaction
// is produced per sample. A regular sample passes through the ring read and
// update, the restoring divider (one quotient bit per cycle), and, when it is
// scaled, the shared 24x31 multiplier used twice and the final add. A restart
// goes straight to the result. Only one sample is in flight; a finished result
// sits in the output register so the next sample can be taken while it waits.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// The ring memory needs no clearing after reset.
`default_nettype none

module windowed_duty_cycle_sleep_regulator import wdcsr_pkg::*; #(
  parameter int RING_DEPTH = 1024,
  parameter int DELTA_BITS = 40
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  wdcsr_in_if.sink                  sample,
  wdcsr_out_if.source               result
);

  localparam int PW       = $clog2(RING_DEPTH);
  localparam int LEN_W    = $clog2(RING_DEPTH + 1);
  localparam int SUM_RAW  = DELTA_BITS + PW + 1;
  localparam int SUM_BITS = (SUM_RAW > TS_BITS) ? TS_BITS : SUM_RAW;
  localparam int ENTRY_W  = 2 * DELTA_BITS;

  // configuration registers
  logic [USAGE_BITS-1:0]  low_threshold;
  logic [USAGE_BITS-1:0]  high_threshold;
  logic [FACTOR_BITS-1:0] grow_factor;
  logic [FACTOR_BITS-1:0] shrink_factor;
  logic [WLEN_BITS-1:0]   window_length;

  // sequencer
  state_t state;
  state_t state_next;
  logic   accept;
  logic   div_start;
  logic   out_load;

  // window state
  logic [ENTRY_W-1:0]    ring [RING_DEPTH];
  logic [ENTRY_W-1:0]    rd_data;
  logic [PW-1:0]         ring_position;
  logic                  ring_filled;
  logic [SUM_BITS-1:0]   wall_sum;
  logic [SUM_BITS-1:0]   busy_sum;
  logic [TS_BITS-1:0]    previous_wall;
  logic [TS_BITS-1:0]    previous_busy;
  logic [DELTA_BITS-1:0] wall_delta;
  logic [DELTA_BITS-1:0] busy_delta;

  // regulation state
  logic [SLEEP_BITS-1:0] sleep_value;
  logic [USAGE_BITS-1:0] last_usage;
  logic [BAND_BITS-1:0]  band_r;
  logic [PROD_BITS-1:0]  prod_lo;
  logic [PROD_BITS-1:0]  prod_hi;

  // datapath nets
  logic [TS_BITS-1:0]     wall_diff;
  logic [TS_BITS-1:0]     busy_diff;
  logic [DELTA_BITS-1:0]  wall_delta_sat;
  logic [DELTA_BITS-1:0]  busy_delta_sat;
  logic [SUM_BITS-1:0]    old_wall;
  logic [SUM_BITS-1:0]    old_busy;
  logic [SUM_BITS:0]      wall_add;
  logic [SUM_BITS:0]      busy_add;
  logic [LEN_W-1:0]       len_eff;
  logic [PW:0]            pos_inc;
  logic                   pos_wrap;
  logic [SLEEP_HALF-1:0]  mul_a;
  logic [FACTOR_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]   mul_p;
  logic [SCALE_BITS-1:0]  scale_sum;
  logic [SLEEP_BITS:0]    scaled;
  logic [SLEEP_BITS-1:0]  scaled_sat;
  logic                   div_done;
  logic [USAGE_BITS-1:0]  div_quotient;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= RST_LOW_THRESHOLD;
      high_threshold <= RST_HIGH_THRESHOLD;
      grow_factor    <= RST_GROW_FACTOR;
      shrink_factor  <= RST_SHRINK_FACTOR;
      window_length  <= RST_WINDOW_LENGTH;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data[USAGE_BITS-1:0];
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data[USAGE_BITS-1:0];
        CFG_GROW_FACTOR:    grow_factor    <= cfg_data[FACTOR_BITS-1:0];
        CFG_SHRINK_FACTOR:  shrink_factor  <= cfg_data[FACTOR_BITS-1:0];
        CFG_WINDOW_LENGTH:  window_length  <= cfg_data[WLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = sample.mode ? ST_DONE : ST_SUB;
        end
      end
      ST_SUB:      state_next = ST_ADD;
      ST_ADD:      state_next = ST_DIV;
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_done) state_next = ST_CLASSIFY;
      ST_CLASSIFY: begin
        if (last_usage < low_threshold || last_usage > high_threshold) begin
          state_next = ST_MUL_LO;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL_LO:   state_next = ST_MUL_HI;
      ST_MUL_HI:   state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_DONE;
      ST_DONE: begin
        // park here until the output register is free
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  assign accept = sample.valid && sample.ready;

  // ---------------------------------------------------------------------------
  // Deltas: modulo-2^64 difference, saturated to DELTA_BITS ones
  // ---------------------------------------------------------------------------
  assign wall_diff      = sample.wall_time - previous_wall;
  assign busy_diff      = sample.busy_time - previous_busy;
  assign wall_delta_sat = ((wall_diff >> DELTA_BITS) != '0) ? '1 : wall_diff[DELTA_BITS-1:0];
  assign busy_delta_sat = ((busy_diff >> DELTA_BITS) != '0) ? '1 : busy_diff[DELTA_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Window bookkeeping
  // ---------------------------------------------------------------------------
  assign old_wall = SUM_BITS'(rd_data[ENTRY_W-1:DELTA_BITS]);
  assign old_busy = SUM_BITS'(rd_data[DELTA_BITS-1:0]);
  assign wall_add = {1'b0, wall_sum} + (SUM_BITS + 1)'(wall_delta);
  assign busy_add = {1'b0, busy_sum} + (SUM_BITS + 1)'(busy_delta);

  // zero acts as one, oversize acts as the ring depth
  always_comb begin
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_length) > 32'(RING_DEPTH)) begin
      len_eff = LEN_W'(RING_DEPTH);
    end else begin
      len_eff = LEN_W'(window_length);
    end
  end

  assign pos_inc  = (PW + 1)'(ring_position) + 1'b1;
  assign pos_wrap = 32'(pos_inc) >= 32'(len_eff);

  // ring memory: one write port, registered read at the current position
  always_ff @(posedge clk) begin
    if (state == ST_ADD) begin
      ring[ring_position] <= {wall_delta, busy_delta};
    end
    rd_data <= ring[ring_position];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: low then high half of sleep_value times the factor
  // ---------------------------------------------------------------------------
  assign mul_a = (state == ST_MUL_HI) ? sleep_value[SLEEP_BITS-1:SLEEP_HALF]
                                      : sleep_value[SLEEP_HALF-1:0];
  assign mul_b = (band_r == BAND_LOW) ? shrink_factor : grow_factor;
  assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  assign scale_sum  = {prod_hi, {SLEEP_HALF{1'b0}}} + SCALE_BITS'(prod_lo);
  assign scaled     = scale_sum[SCALE_BITS-1:Q_SHIFT];
  assign scaled_sat = scaled[SLEEP_BITS] ? '1 : scaled[SLEEP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (state == ST_MUL_LO) prod_lo <= mul_p;
    if (state == ST_MUL_HI) prod_hi <= mul_p;
    if (accept) begin
      wall_delta <= wall_delta_sat;
      busy_delta <= busy_delta_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Usage divider
  // ---------------------------------------------------------------------------
  wdcsr_divider #(
    .SUM_BITS (SUM_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (busy_sum),
    .divisor  (wall_sum),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // ---------------------------------------------------------------------------
  // Block state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
      ring_filled   <= 1'b0;
      wall_sum      <= '0;
      busy_sum      <= '0;
      previous_wall <= '0;
      previous_busy <= '0;
      sleep_value   <= SLEEP_ONE;
      last_usage    <= '0;
      band_r        <= BAND_MID;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            previous_wall <= sample.wall_time;
            previous_busy <= sample.busy_time;
            band_r        <= BAND_MID;
            if (sample.mode) begin
              ring_position <= '0;
              ring_filled   <= 1'b0;
              wall_sum      <= '0;
              busy_sum      <= '0;
            end
          end
        end
        ST_SUB: begin
          // retire the entry about to be overwritten, floored at zero
          if (ring_filled) begin
            wall_sum <= (wall_sum > old_wall) ? (wall_sum - old_wall) : '0;
            busy_sum <= (busy_sum > old_busy) ? (busy_sum - old_busy) : '0;
          end
        end
        ST_ADD: begin
          wall_sum <= wall_add[SUM_BITS] ? '1 : wall_add[SUM_BITS-1:0];
          busy_sum <= busy_add[SUM_BITS] ? '1 : busy_add[SUM_BITS-1:0];
          if (pos_wrap) begin
            ring_position <= '0;
            ring_filled   <= 1'b1;
          end else begin
            ring_position <= pos_inc[PW-1:0];
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) last_usage <= div_quotient;
        end
        ST_CLASSIFY: begin
          if (last_usage < low_threshold) begin
            band_r <= BAND_LOW;
          end else if (last_usage > high_threshold) begin
            band_r <= BAND_HIGH;
          end
        end
        ST_SCALE: begin
          if (band_r == BAND_LOW && scaled_sat == '0) begin
            sleep_value <= SLEEP_ONE;
          end else begin
            sleep_value <= scaled_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.sleep_ns    <= sleep_value[SLEEP_BITS-1:SLEEP_BITS-SLEEP_NS_BITS];
      result.usage_q16   <= last_usage;
      result.band        <= band_r;
      result.window_full <= ring_filled;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SUB || state == ST_DONE))
    else $error("sample transaction did not start a sequence");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_sleep_nonzero: assert property (@(posedge clk) disable iff (rst)
    sleep_value != '0)
    else $error("sleep value dropped to zero");

  a_usage_range: assert property (@(posedge clk) disable iff (rst)
    last_usage <= ONE_Q16)
    else $error("usage above 1.0");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(ring_position) < 32'(RING_DEPTH))
    else $error("ring position beyond depth");

endmodule

`default_nettype wire
